FILE: rtl/clde_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clde_pkg: shared types and constants of the cell raster draw engine
// Command codes, draw modes, payload structs and the queue entry format.
// ----------------------------------------------------------------------------
package clde_pkg;

  localparam int MaxCellsDefault = 8;
  localparam int CellRows = 7;
  localparam int CellColumns = 5;
  localparam logic [4:0] PixelMask = 5'h1F;

  localparam logic [2:0] CMD_CLEAR = 3'd0;
  localparam logic [2:0] CMD_PIXEL = 3'd1;
  localparam logic [2:0] CMD_LINE  = 3'd2;
  localparam logic [2:0] CMD_HLINE = 3'd3;
  localparam logic [2:0] CMD_VLINE = 3'd4;
  localparam logic [2:0] CMD_FILL  = 3'd5;
  localparam logic [2:0] CMD_READ  = 3'd6;
  // The remaining code does nothing and answers zero.
  localparam logic [2:0] CMD_SPARE = 3'd7;

  // Draw modes that change a pixel; all other modes leave it alone.
  localparam logic [2:0] MODE_FLIP      = 3'd0;
  localparam logic [2:0] MODE_SET       = 3'd2;
  localparam logic [2:0] MODE_SET_ALT   = 3'd3;
  localparam logic [2:0] MODE_CLEAR     = 3'd5;
  localparam logic [2:0] MODE_CLEAR_ALT = 3'd7;

  localparam logic [1:0] REG_CELLS_ACROSS = 2'd0;
  localparam logic [1:0] REG_CELLS_DOWN   = 2'd1;
  localparam logic [1:0] REG_DRAW_MODE    = 2'd2;

  // Work kinds handed from the front part to the back part.
  localparam logic [2:0] JOB_NONE  = 3'd0;
  localparam logic [2:0] JOB_CLEAR = 3'd1;
  localparam logic [2:0] JOB_RECT  = 3'd2;
  localparam logic [2:0] JOB_LINE  = 3'd3;
  localparam logic [2:0] JOB_READ  = 3'd4;

  typedef struct packed {
    logic [2:0]        command;
    logic signed [7:0] x_first;
    logic signed [7:0] y_first;
    logic signed [7:0] x_second;
    logic signed [7:0] y_second;
    logic signed [7:0] rect_width;
    logic signed [7:0] rect_height;
    logic [5:0]        read_index;
  } cmd_t;

  typedef struct packed {
    logic [4:0] read_data;
    logic       ignored;
  } result_t;

  // Classified job: rectangles are already clipped, coordinates are 10 bits
  // signed so line endpoints keep their full range.
  typedef struct packed {
    logic [2:0]        kind;
    logic              ignored;
    logic signed [9:0] xa;
    logic signed [9:0] ya;
    logic signed [9:0] xb;
    logic signed [9:0] yb;
    logic [5:0]        index;
  } job_t;

endpackage

FILE: rtl/clde_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clde_front: command classifier
// Takes commands, checks the cell count and clips spans to the pixel area.
// ----------------------------------------------------------------------------
module clde_front #(
  parameter int MAX_CELLS = clde_pkg::MaxCellsDefault
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  clde_pkg::cmd_t in_cmd,
  input  logic [3:0]    cells_across,
  input  logic [1:0]    cells_down,
  output logic          job_valid,
  input  logic          job_stall,
  output clde_pkg::job_t job
);
  import clde_pkg::*;

  logic [5:0] cells;
  logic signed [9:0] pw, ph, x1, y1, x2, y2, w, h;
  logic signed [9:0] lx, hx, ly, hy;
  job_t job_next;

  assign cells = cells_across * cells_down;
  assign pw = 10'(cells_across) * 10'sd5;
  assign ph = 10'(cells_down) * 10'sd7;
  assign x1 = 10'(in_cmd.x_first);
  assign y1 = 10'(in_cmd.y_first);
  assign x2 = 10'(in_cmd.x_second);
  assign y2 = 10'(in_cmd.y_second);
  assign w = 10'(in_cmd.rect_width);
  assign h = 10'(in_cmd.rect_height);

  always_comb begin
    lx = x1; hx = x1; ly = y1; hy = y1;
    job_next = '0;
    job_next.index = in_cmd.read_index;
    if (cells > 6'(MAX_CELLS)) begin
      job_next.ignored = 1'b1;
    end else begin
      case (in_cmd.command)
        CMD_CLEAR: job_next.kind = JOB_CLEAR;
        CMD_PIXEL: job_next.kind = JOB_RECT;
        CMD_LINE: begin
          job_next.kind = JOB_LINE;
        end
        CMD_HLINE: begin
          job_next.kind = JOB_RECT;
          if (x2 < x1) lx = x2; else hx = x2;
        end
        CMD_VLINE: begin
          job_next.kind = JOB_RECT;
          if (y2 < y1) ly = y2; else hy = y2;
        end
        CMD_FILL: begin
          if (w > 0 && h > 0) job_next.kind = JOB_RECT;
          hx = x1 + w - 10'sd1;
          hy = y1 + h - 10'sd1;
        end
        CMD_READ: job_next.kind = JOB_READ;
        default: job_next.kind = JOB_NONE;
      endcase
      if (job_next.kind == JOB_LINE) begin
        job_next.xa = x1; job_next.ya = y1;
        job_next.xb = x2; job_next.yb = y2;
      end else begin
        job_next.xa = (lx < 0) ? 10'sd0 : lx;
        job_next.ya = (ly < 0) ? 10'sd0 : ly;
        job_next.xb = (hx > pw - 10'sd1) ? pw - 10'sd1 : hx;
        job_next.yb = (hy > ph - 10'sd1) ? ph - 10'sd1 : hy;
      end
    end
  end

  assign in_stall = job_valid && job_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else if (!in_stall) begin
      job_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      job <= job_next;
    end
  end
endmodule

FILE: rtl/clde_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clde_queue: two-entry job queue
// Decouples the classifier from the draw sequencer.
// ----------------------------------------------------------------------------
module clde_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_stall,
  input  clde_pkg::job_t wr_job,
  output logic           rd_valid,
  input  logic           rd_stall,
  output clde_pkg::job_t rd_job
);
  import clde_pkg::*;

  job_t mem [2];
  logic wp, rp;
  logic [1:0] count;
  logic push, pop;

  assign wr_stall = (count == 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_job = mem[rp];
  assign push = wr_valid && !wr_stall;
  assign pop = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_job;
  end
endmodule

FILE: rtl/clde_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// clde_back: draw sequencer
// Walks each job over the frame store with read-modify-write cycles.
// ----------------------------------------------------------------------------
module clde_back #(
  parameter int MAX_CELLS = clde_pkg::MaxCellsDefault
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           job_valid,
  output logic           job_stall,
  input  clde_pkg::job_t job,
  input  logic [3:0]     cells_across,
  input  logic [1:0]     cells_down,
  input  logic [2:0]     draw_mode,
  output logic           out_valid,
  input  logic           out_stall,
  output clde_pkg::result_t result
);
  import clde_pkg::*;

  localparam logic [2:0] S_WIPE  = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_PLOT  = 3'd2;
  localparam logic [2:0] S_WRITE = 3'd3;
  localparam logic [2:0] S_READ  = 3'd4;
  localparam logic [2:0] S_CLEAR = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  localparam int Depth = MAX_CELLS * CellRows;

  logic [4:0] store [Depth];
  logic [4:0] rdata;
  logic [2:0] state;
  job_t cur;
  logic signed [9:0] x, y, d, inc_a, inc_b, pw, ph;
  logic [8:0] left;
  logic signed [1:0] xa_s, ya_s, xb_s, yb_s;
  logic [5:0] addr, clr_cnt, clr_lim;
  logic hit;

  // Pixel address helpers for the current point.
  logic [3:0] cellx;
  logic [2:0] colx;
  logic [6:0] pidx;
  logic inside_area, last_point;
  logic signed [9:0] adx, ady;
  logic [4:0] mask, newv;

  assign pw = 10'(cells_across) * 10'sd5;
  assign ph = 10'(cells_down) * 10'sd7;
  assign clr_lim = 6'(cells_across) * 6'(cells_down) * 6'd7;

  always_comb begin
    cellx = 4'd0;
    colx = 3'd0;
    if (x >= 10'sd35)      begin cellx = 4'd7; colx = 3'(x - 10'sd35); end
    else if (x >= 10'sd30) begin cellx = 4'd6; colx = 3'(x - 10'sd30); end
    else if (x >= 10'sd25) begin cellx = 4'd5; colx = 3'(x - 10'sd25); end
    else if (x >= 10'sd20) begin cellx = 4'd4; colx = 3'(x - 10'sd20); end
    else if (x >= 10'sd15) begin cellx = 4'd3; colx = 3'(x - 10'sd15); end
    else if (x >= 10'sd10) begin cellx = 4'd2; colx = 3'(x - 10'sd10); end
    else if (x >= 10'sd5)  begin cellx = 4'd1; colx = 3'(x - 10'sd5); end
    else                   begin cellx = 4'd0; colx = 3'(x); end
  end

  assign inside_area = (x >= 0) && (x < pw) && (y >= 0) && (y < ph);
  assign pidx = 7'(ph) * 7'(cellx) + 7'(y);
  assign last_point = (cur.kind == JOB_LINE) ? (left == 9'd0)
                    : (x == cur.xb && y == cur.yb);
  assign mask = 5'b10000 >> colx;

  always_comb begin
    case (draw_mode)
      MODE_FLIP: newv = rdata ^ mask;
      MODE_SET, MODE_SET_ALT: newv = rdata | mask;
      MODE_CLEAR, MODE_CLEAR_ALT: newv = rdata & ~mask;
      default: newv = rdata;
    endcase
  end

  assign adx = (job.xb > job.xa) ? job.xb - job.xa : job.xa - job.xb;
  assign ady = (job.yb > job.ya) ? job.yb - job.ya : job.ya - job.yb;
  assign job_stall = (state != S_IDLE) || out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_WIPE;
      clr_cnt <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_WIPE: begin
          clr_cnt <= clr_cnt + 6'd1;
          if (clr_cnt == 6'(Depth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (job_valid && !job_stall) begin
            cur <= job;
            result <= '{read_data: 5'd0, ignored: job.ignored};
            x <= job.xa;
            y <= job.ya;
            clr_cnt <= 6'd0;
            if (adx >= ady) begin
              left <= 9'(adx);
              d <= 10'sd2 * ady - adx;
              inc_a <= 10'sd2 * ady;
              inc_b <= 10'sd2 * (ady - adx);
              xa_s <= (job.xa > job.xb) ? -2'sd1 : 2'sd1;
              ya_s <= 2'sd0;
            end else begin
              left <= 9'(ady);
              d <= 10'sd2 * adx - ady;
              inc_a <= 10'sd2 * adx;
              inc_b <= 10'sd2 * (adx - ady);
              xa_s <= 2'sd0;
              ya_s <= (job.ya > job.yb) ? -2'sd1 : 2'sd1;
            end
            xb_s <= (job.xa > job.xb) ? -2'sd1 : 2'sd1;
            yb_s <= (job.ya > job.yb) ? -2'sd1 : 2'sd1;
            case (job.kind)
              JOB_CLEAR: state <= S_CLEAR;
              JOB_READ:  state <= S_READ;
              JOB_LINE:  state <= S_PLOT;
              JOB_RECT:  state <= (job.xa <= job.xb && job.ya <= job.yb) ? S_PLOT : S_DONE;
              default:   state <= S_DONE;
            endcase
          end
        end
        S_PLOT: begin
          hit <= inside_area && (pidx < 7'(Depth));
          addr <= 6'(pidx);
          state <= S_WRITE;
        end
        S_WRITE: begin
          if (last_point) begin
            state <= S_DONE;
          end else begin
            state <= S_PLOT;
            if (cur.kind == JOB_LINE) begin
              left <= left - 9'd1;
              if (d < 0) begin
                d <= d + inc_a; x <= x + 10'(xa_s); y <= y + 10'(ya_s);
              end else begin
                d <= d + inc_b; x <= x + 10'(xb_s); y <= y + 10'(yb_s);
              end
            end else if (y == cur.yb) begin
              y <= cur.ya;
              x <= x + 10'sd1;
            end else begin
              y <= y + 10'sd1;
            end
          end
        end
        S_READ: begin
          if (clr_cnt == 6'd0) begin
            clr_cnt <= 6'd1;
          end else begin
            if (cur.index < 6'(Depth)) result.read_data <= rdata;
            state <= S_DONE;
          end
        end
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 6'd1;
          if (clr_cnt + 6'd1 >= clr_lim || clr_cnt == 6'(Depth - 1)) state <= S_DONE;
        end
        S_DONE: begin
          out_valid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Store: one write port, registered read.
  always_ff @(posedge clk) begin
    if (state == S_WIPE) begin
      store[clr_cnt] <= 5'd0;
    end else if (state == S_CLEAR && clr_lim != 6'd0) begin
      store[clr_cnt] <= draw_mode[2] ? PixelMask : 5'd0;
    end else if (state == S_WRITE && hit) begin
      store[addr] <= newv;
    end
    if (state == S_READ) rdata <= store[(cur.index < 6'(Depth)) ? cur.index : 6'd0];
    else rdata <= store[(pidx < 7'(Depth)) ? 6'(pidx) : 6'd0];
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(result))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    state == S_WRITE |-> $past(state) == S_PLOT)
    else $error("write without plot");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> result.ignored || cur.kind == JOB_READ || result.read_data == 5'd0)
    else $error("read data on non-read");
endmodule

FILE: rtl/cell_lcd_raster_draw_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_lcd_raster_draw_engine: character-cell bitmap draw engine
// Clear, pixel, line, span, fill and read commands on a 5x7-cell store.
// ----------------------------------------------------------------------------
// Each accepted transaction yields exactly one result transaction. A command
// passes a classifier stage, waits in a two-entry queue and is then carried
// out by a sequencer that updates the 56-entry frame store one pixel at a
// time, reading the entry in S_PLOT and writing it back in S_WRITE. A line
// walks up to 256 pixels and the largest fill covers 280; a clear writes
// each entry in turn, a read fetches one entry, and an ignored or empty
// command goes straight to its result. After reset the store is wiped in
// S_WIPE before the first command is carried out.
// Configuration writes are taken at any time but must only be issued while
// the engine is idle.
module cell_lcd_raster_draw_engine #(
  parameter int MAX_CELLS = clde_pkg::MaxCellsDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  clde_pkg::cmd_t    in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output clde_pkg::result_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_index,
  input  logic [3:0]        cfg_data
);
  import clde_pkg::*;

  logic [3:0] cells_across;
  logic [1:0] cells_down;
  logic [2:0] draw_mode;
  logic f_valid, f_stall, q_valid, q_stall;
  job_t f_job, q_job;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cells_across <= 4'd1;
      cells_down <= 2'd1;
      draw_mode <= 3'd3;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_CELLS_ACROSS: cells_across <= cfg_data;
        REG_CELLS_DOWN: cells_down <= cfg_data[1:0];
        REG_DRAW_MODE: draw_mode <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  clde_front #(.MAX_CELLS(MAX_CELLS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_cmd(in_data),
    .cells_across, .cells_down,
    .job_valid(f_valid), .job_stall(f_stall), .job(f_job)
  );

  clde_queue u_queue (
    .clk, .rst, .wr_valid(f_valid), .wr_stall(f_stall), .wr_job(f_job),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_job(q_job)
  );

  clde_back #(.MAX_CELLS(MAX_CELLS)) u_back (
    .clk, .rst, .job_valid(q_valid), .job_stall(q_stall), .job(q_job),
    .cells_across, .cells_down, .draw_mode,
    .out_valid, .out_stall, .result(out_data)
  );
endmodule
